// ----- src/jse_pkg.sv -----
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types and constants for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

	typedef enum logic [1:0] {
		ACT_RESET = 2'd0,
		ACT_OPEN  = 2'd1,
		ACT_DATA  = 2'd2,
		ACT_CLOSE = 2'd3
	} action_t;

	localparam int unsigned CHUNK_MAX   = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] CHR_QUOTE = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5c;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;
	localparam logic [3:0] NIBBLE_MASK = 4'hf;

	localparam logic [15:0][7:0] HEX_CHARS = {
		8'h66, 8'h65, 8'h64, 8'h63, 8'h62, 8'h61, 8'h39, 8'h38,
		8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
	};

	// One classified item as it waits in the queue.
	typedef struct packed {
		logic                           is_reset;
		logic [2:0]                     chunk_len;
		logic [CHUNK_MAX-1:0][7:0]      chunk;
		logic [15:0]                    preset;
	} desc_t;

	typedef struct packed {
		logic       head_valid;
		logic       full;
		logic [1:0] count;
	} queue_status_t;

endpackage

// ----- src/json_string_escaper.sv -----
// ----------------------------------------------------------------------------
// json_string_escaper
// Writes a byte stream into a bounded record as a quoted JSON string.
// ----------------------------------------------------------------------------
// Each input transfer carries one action: reset the used length to a preset
// (which also clears the sticky failure flag), an opening quote, one data
// byte to escape, or a closing quote. The block returns one output transfer
// per emitted byte, with last set on the final byte of the chunk, or a single
// status transfer (byte_valid low, last high) for a reset, for a chunk that
// does not fit and for any action after a failure. A chunk of 1, 2 or 6
// bytes is emitted only when used plus its length is at most capacity minus
// one; otherwise nothing is emitted and failed stays high until the next
// reset action. Output bytes leave at one per cycle while out_ready is high:
// an item holds the back end until its last byte or its status result has
// left, so while a data byte that becomes a two- or six-byte escape drains,
// the two-entry queue fills and in_ready drops. Each item waits in the queue
// and its first result is then registered in the output register. Capacity
// is written through cfg_we and cfg_data and must only change while the
// block is idle.
// ----------------------------------------------------------------------------
module json_string_escaper import jse_pkg::*; #(
	parameter int unsigned LENGTH_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [15:0] preset_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        last,
	output logic        failed,
	output logic [15:0] used_length
);

	// Handshake and descriptor traffic between the three parts.
	logic          push;
	desc_t         push_desc;
	logic          pop;
	desc_t         head_desc;
	queue_status_t status;

	// The front classifies the action and builds the escape chunk.
	jse_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.data_byte     (data_byte),
		.preset_length (preset_length),
		.queue_full    (status.full),
		.push          (push),
		.push_desc     (push_desc)
	);

	// The queue lets the front keep taking items while the back serializes.
	jse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.status    (status)
	);

	// The back owns the length and failure state and the output register.
	jse_back #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.status      (status),
		.head_desc   (head_desc),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last        (last),
		.failed      (failed),
		.used_length (used_length)
	);

	// A failed result never carries a byte.
	a_failed_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> !byte_valid)
		else $error("failed result carries a byte");

	// A status result is always the only, and so the last, result of its item.
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> last)
		else $error("status result without last");

	// The queue never holds more than its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		status.count <= 2'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// Nothing is pushed into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push)
		else $error("push into full queue");

endmodule

// ----- src/jse_front.sv -----
// ----------------------------------------------------------------------------
// jse_front
// Accepts input items and turns each into a chunk descriptor for the queue.
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [15:0] preset_length,
	input  logic        queue_full,
	output logic        push,
	output desc_t       push_desc
);

	action_t act;

	assign act      = action_t'(action);
	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_desc           = '0;
		push_desc.preset    = preset_length;
		push_desc.chunk_len = 3'd1;
		push_desc.chunk[0]  = CHR_QUOTE;
		case (act)
			ACT_RESET: begin
				push_desc.is_reset = 1'b1;
			end
			ACT_DATA: begin
				push_desc.chunk[0]  = CHR_BSLASH;
				push_desc.chunk_len = 3'd2;
				case (data_byte)
					CHR_QUOTE:  push_desc.chunk[1] = CHR_QUOTE;
					CHR_BSLASH: push_desc.chunk[1] = CHR_BSLASH;
					8'h08:      push_desc.chunk[1] = 8'h62;
					8'h0c:      push_desc.chunk[1] = 8'h66;
					8'h0a:      push_desc.chunk[1] = 8'h6e;
					8'h0d:      push_desc.chunk[1] = 8'h72;
					8'h09:      push_desc.chunk[1] = 8'h74;
					default: begin
						if (data_byte < CTRL_LIMIT) begin
							push_desc.chunk_len = 3'd6;
							push_desc.chunk[1]  = 8'h75;
							push_desc.chunk[2]  = 8'h30;
							push_desc.chunk[3]  = 8'h30;
							push_desc.chunk[4]  = HEX_CHARS[data_byte[7:4] & NIBBLE_MASK];
							push_desc.chunk[5]  = HEX_CHARS[data_byte[3:0] & NIBBLE_MASK];
						end else begin
							push_desc.chunk_len = 3'd1;
							push_desc.chunk[0]  = data_byte;
						end
					end
				endcase
			end
			default: begin
				// Open and close quotes share the one-byte quote chunk.
				push_desc.chunk[0] = CHR_QUOTE;
			end
		endcase
	end

endmodule

// ----- src/jse_queue.sv -----
// ----------------------------------------------------------------------------
// jse_queue
// Two-entry descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
module jse_queue import jse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  desc_t         push_desc,
	input  logic          pop,
	output desc_t         head_desc,
	output queue_status_t status
);

	desc_t      mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	assign head_desc         = mem_q[rd_ptr_q];
	assign status.head_valid = (count_q != 2'd0);
	assign status.full       = (count_q == 2'(QUEUE_DEPTH));
	assign status.count      = count_q;

endmodule

// ----- src/jse_back.sv -----
// ----------------------------------------------------------------------------
// jse_back
// Holds the record length and failure flag, checks each chunk against the
// capacity and serializes its bytes into the output register.
// ----------------------------------------------------------------------------
module jse_back import jse_pkg::*; #(
	parameter int unsigned LENGTH_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_data,
	input  queue_status_t status,
	input  desc_t         head_desc,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          last,
	output logic          failed,
	output logic [15:0]   used_length
);

	localparam int unsigned SW = ((LENGTH_WIDTH > 16) ? LENGTH_WIDTH : 16) + 1;
	localparam logic [15:0] CAPACITY_RESET = 16'd3264;

	logic [15:0]             capacity_q;
	logic [LENGTH_WIDTH-1:0] used_q;
	logic                    ovf_q;
	logic [2:0]              idx_q;

	logic                    advance;
	logic [SW-1:0]           need;
	logic                    fits;
	logic                    is_last_byte;
	logic [LENGTH_WIDTH-1:0] used_inc;
	logic [LENGTH_WIDTH+15:0] preset_ext;
	logic [LENGTH_WIDTH-1:0] used_next;
	logic [LENGTH_WIDTH+15:0] used_ext;

	assign advance      = status.head_valid && (!out_valid || out_ready);
	assign need         = SW'(used_q) + SW'(head_desc.chunk_len) + SW'(1);
	assign fits         = (need <= SW'(capacity_q));
	assign is_last_byte = (idx_q == (head_desc.chunk_len - 3'd1));
	assign used_inc     = used_q + LENGTH_WIDTH'(1);
	assign preset_ext   = {{LENGTH_WIDTH{1'b0}}, head_desc.preset};

	always_comb begin
		pop       = 1'b0;
		used_next = used_q;
		if (advance) begin
			if (head_desc.is_reset) begin
				pop       = 1'b1;
				used_next = preset_ext[LENGTH_WIDTH-1:0];
			end else if (idx_q == 3'd0 && (ovf_q || !fits)) begin
				pop = 1'b1;
			end else begin
				pop       = is_last_byte;
				used_next = used_inc;
			end
		end
	end

	assign used_ext = {16'b0, used_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			used_q     <= '0;
			ovf_q      <= 1'b0;
			idx_q      <= 3'd0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_we) capacity_q <= cfg_data;
			if (out_ready) out_valid <= 1'b0;
			if (advance) begin
				out_valid <= 1'b1;
				used_q    <= used_next;
				if (head_desc.is_reset) begin
					ovf_q <= 1'b0;
					idx_q <= 3'd0;
				end else if (idx_q == 3'd0 && (ovf_q || !fits)) begin
					ovf_q <= 1'b1;
				end else if (is_last_byte) begin
					idx_q <= 3'd0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			used_length <= used_ext[15:0];
			if (head_desc.is_reset) begin
				out_byte   <= 8'h00;
				byte_valid <= 1'b0;
				last       <= 1'b1;
				failed     <= 1'b0;
			end else if (idx_q == 3'd0 && (ovf_q || !fits)) begin
				out_byte   <= 8'h00;
				byte_valid <= 1'b0;
				last       <= 1'b1;
				failed     <= 1'b1;
			end else begin
				out_byte   <= head_desc.chunk[idx_q];
				byte_valid <= 1'b1;
				last       <= is_last_byte;
				failed     <= 1'b0;
			end
		end
	end

endmodule

// ----- tb/sv/json_string_escaper_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_checker
// Scoreboard for the JSON string escaper: it watches the configuration
// port and both channels, keeps its own copy of the record state, predicts
// every output transfer and compares each one, field by field, in order.
// ----------------------------------------------------------------------------
module json_string_escaper_checker import jse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [15:0] preset_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        byte_valid,
	input  logic        last,
	input  logic        failed,
	input  logic [15:0] used_length,
	output int          errors,
	output int          outstanding
);

	localparam logic [15:0] CAPACITY_AT_RESET = 16'd3264;

	localparam logic [7:0] CHR_BACKSPACE = 8'h08;
	localparam logic [7:0] CHR_TAB       = 8'h09;
	localparam logic [7:0] CHR_NEWLINE   = 8'h0a;
	localparam logic [7:0] CHR_FORMFEED  = 8'h0c;
	localparam logic [7:0] CHR_RETURN    = 8'h0d;

	// One output transfer as the record writer should produce it.
	typedef struct packed {
		logic [7:0]  ch;
		logic        valid;
		logic        tail;
		logic        fail;
		logic [15:0] used;
	} record_out_t;

	record_out_t expected_q[$];
	logic [15:0] capacity_reg = CAPACITY_AT_RESET;
	logic [15:0] used_count   = '0;
	logic        overflowed   = 1'b0;
	int          error_total  = 0;
	int          queued_count = 0;

	assign errors      = error_total;
	assign outstanding = queued_count;

	function automatic logic [7:0] hex_digit(logic [3:0] nib);
		if (nib < 4'd10) begin
			return "0" + 8'(nib);
		end
		return "a" + 8'(nib) - 8'd10;
	endfunction

	function automatic void push_result(logic [7:0] ch, logic valid, logic tail);
		record_out_t r;
		r.ch    = ch;
		r.valid = valid;
		r.tail  = tail;
		r.fail  = overflowed;
		r.used  = used_count;
		expected_q.push_back(r);
	endfunction

	// Updates the record state for one accepted item and queues its results.
	function automatic void escape_item(action_t act, logic [7:0] b, logic [15:0] preset);
		logic [7:0] seq [CHUNK_MAX];
		int         n;
		if (act == ACT_RESET) begin
			used_count = preset;
			overflowed = 1'b0;
			push_result(8'd0, 1'b0, 1'b1);
			return;
		end
		if (overflowed) begin
			push_result(8'd0, 1'b0, 1'b1);
			return;
		end
		seq[0] = CHR_QUOTE;
		n = 1;
		if (act == ACT_DATA) begin
			seq[0] = CHR_BSLASH;
			n = 2;
			case (b)
				CHR_QUOTE:     seq[1] = CHR_QUOTE;
				CHR_BSLASH:    seq[1] = CHR_BSLASH;
				CHR_BACKSPACE: seq[1] = "b";
				CHR_FORMFEED:  seq[1] = "f";
				CHR_NEWLINE:   seq[1] = "n";
				CHR_RETURN:    seq[1] = "r";
				CHR_TAB:       seq[1] = "t";
				default: begin
					if (b < CTRL_LIMIT) begin
						seq[1] = "u";
						seq[2] = "0";
						seq[3] = "0";
						seq[4] = hex_digit(b[7:4]);
						seq[5] = hex_digit(b[3:0]);
						n = 6;
					end else begin
						seq[0] = b;
						n = 1;
					end
				end
			endcase
		end
		// One byte of the record is kept back for the terminator.
		if (32'(used_count) + n + 1 > 32'(capacity_reg)) begin
			overflowed = 1'b1;
			push_result(8'd0, 1'b0, 1'b1);
			return;
		end
		for (int k = 0; k < n; k++) begin
			used_count = used_count + 16'd1;
			push_result(seq[k], 1'b1, k == n - 1);
		end
	endfunction

	function automatic void compare_field(string name, logic [15:0] exp, logic [15:0] got);
		if (exp !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, exp, got);
			error_total++;
		end
	endfunction

	function automatic void check_output();
		record_out_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected output transfer, expected none, actual 0x%0h",
				$time, {out_byte, byte_valid, last, failed, used_length});
			error_total++;
			return;
		end
		e = expected_q.pop_front();
		compare_field("out_byte", 16'(e.ch), 16'(out_byte));
		compare_field("byte_valid", 16'(e.valid), 16'(byte_valid));
		compare_field("last", 16'(e.tail), 16'(last));
		compare_field("failed", 16'(e.fail), 16'(failed));
		compare_field("used_length", e.used, used_length);
	endfunction

	// Output transfers are checked before a new input transfer is predicted,
	// so an output that arrives with nothing queued is never matched against
	// an item that was only just accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_reg = CAPACITY_AT_RESET;
			used_count   = '0;
			overflowed   = 1'b0;
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				check_output();
			end
			if (in_valid && in_ready) begin
				escape_item(action_t'(action), data_byte, preset_length);
			end
			if (cfg_we) begin
				capacity_reg = cfg_data;
			end
		end
		queued_count = expected_q.size();
	end

endmodule

// ----- tb/sv/json_string_escaper_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_escaper_test
// Stimulus and verdict for the JSON string escaper.
// ----------------------------------------------------------------------------
// A short directed run covers every action, each escape class and the
// overflow and sticky-failure paths at the reset capacity. Random phases
// then sweep the capacity register over its extremes and a few middle
// values, sending mostly well-formed strings (reset, open quote, data bytes,
// close quote) mixed with noise items. The checker instance beside the block
// predicts and compares every output transfer; this module only drives the
// ports, throttles both channels and reports the result.
// ----------------------------------------------------------------------------
module json_string_escaper_test;

	import jse_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	localparam int MAX_GAP      = 18;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 47;
	// The slowest correct run is at most about 400 items, each with six
	// results that each wait out a full receiver stall, plus the sender gaps
	// and the long hold; the limit below is several times that.
	localparam int CYCLE_LIMIT  = 400000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic [15:0] preset_length;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        last;
	logic        failed;
	logic [15:0] used_length;

	int errors;
	int outstanding;
	int cycle_count   = 0;
	int items_sent    = 0;
	bit no_idle       = 1'b0;
	bit hold_request  = 1'b0;

	json_string_escaper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.data_byte     (data_byte),
		.preset_length (preset_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.last          (last),
		.failed        (failed),
		.used_length   (used_length)
	);

	json_string_escaper_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.data_byte     (data_byte),
		.preset_length (preset_length),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.last          (last),
		.failed        (failed),
		.used_length   (used_length),
		.errors        (errors),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Watchdog: a hung handshake or a result that never arrives ends here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int draw_gap();
		if (no_idle) begin
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Data bytes are weighted toward the interesting classes: printable
	// text, control bytes, the quote and the backslash (each escaped by a pair),
	// and anything at all including the upper half.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'($urandom_range(8'h20, 8'h7e));
			4, 5:       return 8'($urandom_range(0, 8'h1f));
			6:          return CHR_QUOTE;
			7:          return CHR_BSLASH;
			default:    return 8'($urandom_range(0, 8'hff));
		endcase
	endfunction

	// Presets mostly leave room, sometimes sit close to the capacity so the
	// last chunks overflow, and now and then take any 16-bit value.
	function automatic logic [15:0] pick_preset(int cap);
		case ($urandom_range(0, 9))
			0:       return 16'($urandom_range(0, 16'hffff));
			1, 2:    return 16'($urandom_range((cap > 20) ? cap - 20 : 0, cap));
			default: return 16'($urandom_range(0, cap / 2));
		endcase
	endfunction

	// Offers one item after a random gap and returns at the edge where the
	// transfer happens. With no gap the valid simply stays high for the
	// next item, so it is never lowered and raised in the same step.
	task automatic send_item(logic [1:0] act, logic [7:0] b, logic [15:0] pre);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		data_byte     <= b;
		preset_length <= pre;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic send_noise();
		send_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
	endtask

	// A well-formed string with random content; now and then the closing
	// quote is dropped so the next reset lands on an unfinished record.
	task automatic send_string(int cap);
		int n;
		send_item(ACT_RESET, 8'($urandom), pick_preset(cap));
		send_item(ACT_OPEN, 8'($urandom), 16'($urandom));
		n = $urandom_range(0, 12);
		repeat (n) send_item(ACT_DATA, pick_byte(), 16'($urandom));
		if ($urandom_range(0, 9) != 0) begin
			send_item(ACT_CLOSE, 8'($urandom), 16'($urandom));
		end
	endtask

	// Samples on the falling edge so the checker has already counted any
	// transfer made at the preceding rising edge.
	task automatic wait_drained();
		do @(negedge clk); while (outstanding != 0);
	endtask

	// The capacity only changes while the block is idle: input parked and
	// every expected result delivered.
	task automatic write_capacity(logic [15:0] value);
		in_valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic run_phase(int cap);
		int start;
		start = items_sent;
		while (items_sent - start < PHASE_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				send_noise();
			end else begin
				send_string(cap);
			end
		end
	endtask

	// Receiver: a random stall before each output transfer. When the
	// stimulus asks for it, one stall is stretched to a long hold so the
	// internal queue fills up and the input side has to wait.
	initial begin : receiver
		int gap;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = draw_gap();
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int capacities [6];
		capacities = '{40, 1, 65535, 0, 12, 3264};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		action        = ACT_RESET;
		data_byte     = '0;
		preset_length = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset capacity: every escape class, bytes at
		// both ends of the range and around the control limit.
		send_item(ACT_RESET, 8'h00, 16'h0000);
		send_item(ACT_OPEN, 8'hff, 16'hffff);
		send_item(ACT_DATA, "A", 16'h0000);
		send_item(ACT_DATA, CHR_QUOTE, 16'h0000);
		send_item(ACT_DATA, CHR_BSLASH, 16'h0000);
		send_item(ACT_DATA, 8'h08, 16'h0000);
		send_item(ACT_DATA, 8'h0c, 16'h0000);
		send_item(ACT_DATA, 8'h0a, 16'h0000);
		send_item(ACT_DATA, 8'h0d, 16'h0000);
		send_item(ACT_DATA, 8'h09, 16'h0000);
		// A zero byte is just another control byte and becomes a \u escape.
		send_item(ACT_DATA, 8'h00, 16'h0000);
		send_item(ACT_DATA, 8'h1f, 16'h0000);
		send_item(ACT_DATA, 8'h1a, 16'h0000);
		send_item(ACT_DATA, 8'h20, 16'h0000);
		send_item(ACT_DATA, 8'h7f, 16'h0000);
		send_item(ACT_DATA, 8'h80, 16'h0000);
		send_item(ACT_DATA, 8'hff, 16'h0000);
		send_item(ACT_CLOSE, 8'h00, 16'h0000);
		// A used length far above the capacity: nothing fits, and the
		// failure stays set for every action until the next reset.
		send_item(ACT_RESET, 8'hff, 16'hffff);
		send_item(ACT_OPEN, 8'h00, 16'h0000);
		send_item(ACT_DATA, "z", 16'h0000);
		send_item(ACT_CLOSE, 8'h00, 16'h0000);
		// Exactly one byte of room: the quote fits, the pair after it does not.
		send_item(ACT_RESET, 8'h00, 16'd3262);
		send_item(ACT_OPEN, 8'h00, 16'h0000);
		send_item(ACT_DATA, CHR_QUOTE, 16'h0000);

		// Random phases over the capacity range, including zero (nothing
		// ever fits) and one (only the terminator byte). The full-scale
		// phase runs without idling and with one long receiver hold.
		foreach (capacities[p]) begin
			write_capacity(16'(capacities[p]));
			no_idle = (p == 2);
			if (p == 2) begin
				hold_request = 1'b1;
			end
			run_phase(capacities[p]);
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
